// File: sv/sparse_matvec_axpby_defines.svh
// ============================================================================
// Assertion macros for the sparse matrix-vector block
// Clocked, reset-qualified assertion shorthands used by the checker.
// ============================================================================
`ifndef SPARSE_MATVEC_AXPBY_DEFINES_SVH
`define SPARSE_MATVEC_AXPBY_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define SMVA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("%m: assertion failed");

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define SMVA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("%m: assertion failed");

`endif

// File: sv/smva_pkg.sv
// ============================================================================
// smva_pkg
// Shared constants, codes and types of the sparse matrix-vector block.
// ============================================================================
package smva_pkg;

    // Vector dimension and field widths.
    localparam int MAX_DIM   = 1024;
    localparam int IDX_W     = 10;
    localparam int VAL_W     = 32;
    localparam int ACC_W     = 48;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Shared multiplier: 33-bit signed by 32-bit signed.
    localparam int MUL_A_W = VAL_W + 1;
    localparam int MUL_P_W = MUL_A_W + VAL_W;
    // Exact alpha*acc + beta*y before scaling.
    localparam int SUM_W   = ACC_W + VAL_W + 1;

    // Reset value of alpha: 1.0 in Q16.16.
    localparam logic [VAL_W-1:0] ALPHA_RESET = VAL_W'(65536);

    // Request codes.
    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_ACCUM = 2'd1,
        REQ_READ  = 2'd2
    } req_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCATTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC_MUL,
        ST_ACC_WB,
        ST_RD_LO,
        ST_RD_HI,
        ST_RD_BY,
        ST_RD_SUM
    } state_t;

    // Control bundle from the sequencer to the datapath.
    typedef struct packed {
        state_t           state;
        logic             accept;
        logic [IDX_W-1:0] clr_addr;
    } ctl_t;

endpackage

// File: sv/sparse_matvec_axpby.sv
// ============================================================================
// sparse_matvec_axpby
// Sparse matrix-vector multiply with scaled add, Q16.16 fixed point.
// ============================================================================
// Usage: a beat is taken on a rising edge with start high and busy low.
// req_type selects a load of x[vec_index], a nonzero (major_index,
// minor_index, value) added into the accumulator store, or a read of
// result vec_index with value as the y element.
// A load finishes in its accept cycle, so busy stays low.
// A nonzero holds busy through ACC_MUL, for the multiply, and ACC_WB, for the
// read-modify-write of the accumulator entry, so the next beat can be taken
// once the block is back in idle.
// A read holds busy through RD_LO, RD_HI, RD_BY and RD_SUM while one shared
// 33x32 multiplier forms alpha*acc in two halves and then beta*y; done pulses
// for one cycle, registered from RD_SUM, and the result on out_index, out_value
// and saturated is valid while done is high; it cannot stall.
// After reset the accumulator store is swept to zero, one entry a cycle, over
// all 1024 entries with busy high; configuration writes are taken anytime.
// Configuration (cfg_we, cfg_index, cfg_wdata) is to be written only while idle; the block does not enforce this.
// ============================================================================
module sparse_matvec_axpby (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          req_type,
    input  logic [smva_pkg::IDX_W-1:0]          vec_index,
    input  logic [smva_pkg::IDX_W-1:0]          major_index,
    input  logic [smva_pkg::IDX_W-1:0]          minor_index,
    input  logic signed [smva_pkg::VAL_W-1:0]   value,
    output logic                                done,
    output logic [smva_pkg::IDX_W-1:0]          out_index,
    output logic signed [smva_pkg::VAL_W-1:0]   out_value,
    output logic                                saturated,
    input  logic                                cfg_we,
    input  logic [smva_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [smva_pkg::VAL_W-1:0]          cfg_wdata
);

    logic                            scatter_reg;
    logic [smva_pkg::VAL_W-1:0]      alpha_reg;
    logic [smva_pkg::VAL_W-1:0]      beta_reg;
    smva_pkg::ctl_t                  ctl;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scatter_reg <= 1'b0;
            alpha_reg   <= smva_pkg::ALPHA_RESET;
            beta_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                smva_pkg::CFG_SCATTER: scatter_reg <= cfg_wdata[0];
                smva_pkg::CFG_ALPHA:   alpha_reg   <= cfg_wdata;
                smva_pkg::CFG_BETA:    beta_reg    <= cfg_wdata;
                default:               scatter_reg <= scatter_reg;
            endcase
        end
    end

    // Sequencer.
    smva_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .busy     (busy),
        .ctl      (ctl)
    );

    // Memories and arithmetic.
    smva_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .scatter_mode (scatter_reg),
        .alpha        ($signed(alpha_reg)),
        .beta         ($signed(beta_reg)),
        .req_type     (req_type),
        .vec_index    (vec_index),
        .major_index  (major_index),
        .minor_index  (minor_index),
        .value        (value),
        .done         (done),
        .out_index    (out_index),
        .out_value    (out_value),
        .saturated    (saturated)
    );

endmodule

// File: sv/smva_ctrl.sv
// ============================================================================
// smva_ctrl
// Sequencer: clearing sweep after reset and the per-beat step sequence.
// ============================================================================
module smva_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  req_type,
    output logic                        busy,
    output smva_pkg::ctl_t              ctl
);

    smva_pkg::state_t                state_reg;
    smva_pkg::state_t                state_next;
    logic [smva_pkg::IDX_W-1:0]      clr_addr_reg;
    logic [smva_pkg::IDX_W-1:0]      clr_addr_next;
    logic                            accept;

    // State and sweep address registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= smva_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Next state. Loads and the unused request code finish in the accept cycle; nonzeros and reads step on.
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        accept        = start && (state_reg == smva_pkg::ST_IDLE);
        unique case (state_reg)
            smva_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + smva_pkg::IDX_W'(1);
                if (clr_addr_reg == smva_pkg::IDX_W'(smva_pkg::MAX_DIM - 1))
                begin
                    state_next = smva_pkg::ST_IDLE;
                end
            end
            smva_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        smva_pkg::REQ_ACCUM: state_next = smva_pkg::ST_ACC_MUL;
                        smva_pkg::REQ_READ:  state_next = smva_pkg::ST_RD_LO;
                        default:             state_next = smva_pkg::ST_IDLE;
                    endcase
                end
            end
            smva_pkg::ST_ACC_MUL: state_next = smva_pkg::ST_ACC_WB;
            smva_pkg::ST_ACC_WB:  state_next = smva_pkg::ST_IDLE;
            smva_pkg::ST_RD_LO:   state_next = smva_pkg::ST_RD_HI;
            smva_pkg::ST_RD_HI:   state_next = smva_pkg::ST_RD_BY;
            smva_pkg::ST_RD_BY:   state_next = smva_pkg::ST_RD_SUM;
            smva_pkg::ST_RD_SUM:  state_next = smva_pkg::ST_IDLE;
        endcase
    end

    assign busy         = (state_reg != smva_pkg::ST_IDLE);
    assign ctl.state    = state_reg;
    assign ctl.accept   = accept;
    assign ctl.clr_addr = clr_addr_reg;

endmodule

// File: sv/smva_dp.sv
// ============================================================================
// smva_dp
// Datapath: x and accumulator memories, shared multiplier, read-back math.
// ============================================================================
module smva_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  smva_pkg::ctl_t                      ctl,
    input  logic                                scatter_mode,
    input  logic signed [smva_pkg::VAL_W-1:0]   alpha,
    input  logic signed [smva_pkg::VAL_W-1:0]   beta,
    input  logic [1:0]                          req_type,
    input  logic [smva_pkg::IDX_W-1:0]          vec_index,
    input  logic [smva_pkg::IDX_W-1:0]          major_index,
    input  logic [smva_pkg::IDX_W-1:0]          minor_index,
    input  logic signed [smva_pkg::VAL_W-1:0]   value,
    output logic                                done,
    output logic [smva_pkg::IDX_W-1:0]          out_index,
    output logic signed [smva_pkg::VAL_W-1:0]   out_value,
    output logic                                saturated
);

    localparam int ACC_E_W = smva_pkg::ACC_W + 1;
    localparam logic [smva_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(smva_pkg::ACC_W-1){1'b1}}};
    localparam logic [smva_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(smva_pkg::ACC_W-1){1'b0}}};
    localparam logic [smva_pkg::VAL_W-1:0] RES_MAX = {1'b0, {(smva_pkg::VAL_W-1){1'b1}}};
    localparam logic [smva_pkg::VAL_W-1:0] RES_MIN = {1'b1, {(smva_pkg::VAL_W-1){1'b0}}};

    // Memories: x entries, and accumulator entries with a sticky clip bit on top.
    logic [smva_pkg::VAL_W-1:0]      x_mem   [smva_pkg::MAX_DIM];
    logic [ACC_E_W-1:0]              acc_mem [smva_pkg::MAX_DIM];

    logic [smva_pkg::VAL_W-1:0]      x_rd_reg;
    logic [ACC_E_W-1:0]              acc_rd_reg;
    logic [smva_pkg::IDX_W-1:0]      idx_reg;
    logic signed [smva_pkg::VAL_W-1:0] val_reg;
    logic signed [smva_pkg::MUL_P_W-1:0] prod_reg;
    logic signed [smva_pkg::SUM_W-1:0] sum_reg;
    logic                            clip_reg;
    logic                            done_reg;
    logic [smva_pkg::IDX_W-1:0]      out_index_reg;
    logic [smva_pkg::VAL_W-1:0]      out_value_reg;
    logic                            sat_reg;

    logic [smva_pkg::IDX_W-1:0]      src_idx;
    logic [smva_pkg::IDX_W-1:0]      dst_idx;
    logic                            is_load;
    logic                            is_accum;
    logic                            is_read;
    logic [smva_pkg::IDX_W-1:0]      acc_rd_addr;
    logic                            acc_we;
    logic [smva_pkg::IDX_W-1:0]      acc_wr_addr;
    logic [ACC_E_W-1:0]              acc_wr_data;

    logic signed [smva_pkg::MUL_A_W-1:0] mul_a;
    logic signed [smva_pkg::VAL_W-1:0]   mul_b;
    logic signed [smva_pkg::MUL_P_W-1:0] mul_p;

    logic signed [smva_pkg::ACC_W-1:0]   prod_q;
    logic signed [ACC_E_W-1:0]           acc_sum;
    logic                                acc_ovf;
    logic [smva_pkg::ACC_W-1:0]          acc_sat;

    logic signed [smva_pkg::SUM_W-1:0]   hi_term;
    logic signed [smva_pkg::SUM_W-1:0]   total;
    logic signed [smva_pkg::SUM_W-1:0]   scaled;
    logic                                res_fits;

    // Request decode and index routing at accept.
    always_comb
    begin
        is_load     = ctl.accept && (req_type == smva_pkg::REQ_LOAD);
        is_accum    = ctl.accept && (req_type == smva_pkg::REQ_ACCUM);
        is_read     = ctl.accept && (req_type == smva_pkg::REQ_READ);
        dst_idx     = scatter_mode ? minor_index : major_index;
        src_idx     = scatter_mode ? major_index : minor_index;
        acc_rd_addr = is_read ? vec_index : dst_idx;
    end

    // X store: written by load beats, read by accumulate beats.
    always_ff @(posedge clk)
    begin
        if (is_load)
        begin
            x_mem[vec_index] <= value;
        end
        if (is_accum)
        begin
            x_rd_reg <= x_mem[src_idx];
        end
    end

    // Accumulator write port: clearing sweep, clear on read, or updated sum.
    always_comb
    begin
        acc_we      = 1'b0;
        acc_wr_addr = idx_reg;
        acc_wr_data = '0;
        priority case (ctl.state)
            smva_pkg::ST_CLEAR:
            begin
                acc_we      = 1'b1;
                acc_wr_addr = ctl.clr_addr;
            end
            smva_pkg::ST_RD_LO:
            begin
                acc_we = 1'b1;
            end
            smva_pkg::ST_ACC_WB:
            begin
                acc_we      = 1'b1;
                acc_wr_data = {acc_rd_reg[smva_pkg::ACC_W] | acc_ovf, acc_sat};
            end
            default:
            begin
                acc_we = 1'b0;
            end
        endcase
    end

    // Accumulator store: one read and one write port, registered read data.
    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_wr_addr] <= acc_wr_data;
        end
        if (is_accum || is_read)
        begin
            acc_rd_reg <= acc_mem[acc_rd_addr];
        end
    end

    // Item registers.
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            idx_reg <= is_read ? vec_index : dst_idx;
            val_reg <= value;
        end
    end

    // Shared multiplier operand selection by step.
    always_comb
    begin
        unique case (ctl.state)
            smva_pkg::ST_ACC_MUL:
            begin
                mul_a = smva_pkg::MUL_A_W'(val_reg);
                mul_b = $signed(x_rd_reg);
            end
            smva_pkg::ST_RD_LO:
            begin
                mul_a = $signed({1'b0, acc_rd_reg[smva_pkg::VAL_W-1:0]});
                mul_b = alpha;
            end
            smva_pkg::ST_RD_HI:
            begin
                mul_a = smva_pkg::MUL_A_W'($signed(
                            acc_rd_reg[smva_pkg::ACC_W-1:smva_pkg::VAL_W]));
                mul_b = alpha;
            end
            default:
            begin
                mul_a = smva_pkg::MUL_A_W'(val_reg);
                mul_b = beta;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
    end

    // Accumulate: floor-shift the product, add, saturate to 48 bits.
    always_comb
    begin
        prod_q  = prod_reg[smva_pkg::FRAC_W + smva_pkg::ACC_W - 1:smva_pkg::FRAC_W];
        acc_sum = ACC_E_W'($signed(acc_rd_reg[smva_pkg::ACC_W-1:0])) + ACC_E_W'(prod_q);
        acc_ovf = acc_sum[smva_pkg::ACC_W] ^ acc_sum[smva_pkg::ACC_W-1];
        if (acc_ovf)
        begin
            acc_sat = acc_sum[smva_pkg::ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_sat = acc_sum[smva_pkg::ACC_W-1:0];
        end
    end

    // Read-back: gather partial products into the exact sum, then scale.
    always_comb
    begin
        hi_term  = smva_pkg::SUM_W'(prod_reg) <<< smva_pkg::VAL_W;
        total    = sum_reg + smva_pkg::SUM_W'(prod_reg);
        scaled   = total >>> smva_pkg::FRAC_W;
        res_fits = (&scaled[smva_pkg::SUM_W-1:smva_pkg::VAL_W-1])
                || !(|scaled[smva_pkg::SUM_W-1:smva_pkg::VAL_W-1]);
    end

    always_ff @(posedge clk)
    begin
        priority case (ctl.state)
            smva_pkg::ST_RD_LO:
            begin
                clip_reg <= acc_rd_reg[smva_pkg::ACC_W];
            end
            smva_pkg::ST_RD_HI:
            begin
                sum_reg <= smva_pkg::SUM_W'(prod_reg);
            end
            smva_pkg::ST_RD_BY:
            begin
                sum_reg <= sum_reg + hi_term;
            end
            default:
            begin
                sum_reg <= sum_reg;
            end
        endcase
    end

    // Result beat registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (ctl.state == smva_pkg::ST_RD_SUM);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.state == smva_pkg::ST_RD_SUM)
        begin
            out_index_reg <= idx_reg;
            sat_reg       <= clip_reg | !res_fits;
            if (res_fits)
            begin
                out_value_reg <= scaled[smva_pkg::VAL_W-1:0];
            end
            else
            begin
                out_value_reg <= scaled[smva_pkg::SUM_W-1] ? RES_MIN : RES_MAX;
            end
        end
    end

    assign done      = done_reg;
    assign out_index = out_index_reg;
    assign out_value = $signed(out_value_reg);
    assign saturated = sat_reg;

endmodule

// File: sv/smva_checker.sv
// ============================================================================
// smva_checker
// Port-level checks of result timing against accepted beats.
// ============================================================================
`include "sparse_matvec_axpby_defines.svh"

module smva_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [1:0]                          req_type,
    input  logic                                done
);

    // A read beat raises done once its read-back states have run, with no stall between.
    `SMVA_ASSERT_IMP(a_read_latency, start && !busy && (req_type == smva_pkg::REQ_READ), ##5 done)

    // Every result beat traces back to an accepted read.
    `SMVA_ASSERT_IMP(a_done_from_read, done, $past(start && !busy && (req_type == smva_pkg::REQ_READ), 5))

    // Results are single-cycle pulses.
    `SMVA_ASSERT_NXT(a_done_pulse, done, !done)

    // A nonzero beat holds off the next one while its update is in flight.
    `SMVA_ASSERT_NXT(a_accum_busy, start && !busy && (req_type == smva_pkg::REQ_ACCUM), busy)

endmodule

bind sparse_matvec_axpby smva_checker u_smva_checker (.*);

// File: tb/sv/tb_sparse_matvec_axpby.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_sparse_matvec_axpby
// Self-checking bench for the sparse matrix-vector multiply with scaled add.
// A predictor keeps its own copy of the x store, the 48-bit accumulators,
// their clip flags and the scale registers. It works out every returned
// element as each beat is taken. Directed beats cover the field extremes,
// accumulator and result clipping, scatter mode and the unused request code.
// Random sparse matrices with random content follow, over several register
// settings and sender idle profiles.
// ============================================================================
module tb_sparse_matvec_axpby;

    localparam logic [1:0]          REQ_UNUSED    = 2'd3;
    localparam int unsigned         CYCLE_LIMIT   = 400000;
    localparam int                  SETTLE_CYCLES = 8;
    localparam int                  RANDOM_BEATS  = 1260;
    localparam int                  NUM_PHASES    = 8;
    localparam longint              ACC_HI        = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint              ACC_LO        = -ACC_HI - 1;
    localparam logic signed [127:0] RES_HI        = 128'sd2147483647;
    localparam logic signed [127:0] RES_LO        = -128'sd2147483648;
    localparam logic [smva_pkg::VAL_W-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [smva_pkg::VAL_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam logic [smva_pkg::VAL_W-1:0] Q_MIN     = 32'h8000_0000;
    localparam logic [smva_pkg::VAL_W-1:0] Q_MAX     = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]                        kind;
        logic [smva_pkg::IDX_W-1:0]        vec;
        logic [smva_pkg::IDX_W-1:0]        major;
        logic [smva_pkg::IDX_W-1:0]        minor;
        logic signed [smva_pkg::VAL_W-1:0] val;
    } beat_t;

    typedef struct packed {
        logic [smva_pkg::IDX_W-1:0]        idx;
        logic signed [smva_pkg::VAL_W-1:0] val;
        logic                              sat;
    } result_t;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  start;
    logic                                  busy;
    logic [1:0]                            req_type;
    logic [smva_pkg::IDX_W-1:0]            vec_index;
    logic [smva_pkg::IDX_W-1:0]            major_index;
    logic [smva_pkg::IDX_W-1:0]            minor_index;
    logic signed [smva_pkg::VAL_W-1:0]     value;
    logic                                  done;
    logic [smva_pkg::IDX_W-1:0]            out_index;
    logic signed [smva_pkg::VAL_W-1:0]     out_value;
    logic                                  saturated;
    logic                                  cfg_we;
    logic [smva_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [smva_pkg::VAL_W-1:0]            cfg_wdata;

    // Predictor state.
    logic                                  mdl_scatter;
    logic signed [smva_pkg::VAL_W-1:0]     mdl_alpha;
    logic signed [smva_pkg::VAL_W-1:0]     mdl_beta;
    logic signed [smva_pkg::VAL_W-1:0]     x_mem [smva_pkg::MAX_DIM];
    bit                                    x_loaded [smva_pkg::MAX_DIM];
    int                                    loaded_idx [$];
    logic signed [smva_pkg::ACC_W-1:0]     acc_mem [smva_pkg::MAX_DIM];
    bit                                    acc_clip [smva_pkg::MAX_DIM];
    result_t                               axpby_due [$];

    int                          idle_pct;
    int unsigned                 cycles_run;
    int                          beats_sent;
    int                          loads_sent;
    int                          nonzeros_sent;
    int                          reads_sent;
    int                          results_checked;
    int                          results_clipped;
    int                          mismatches;

    sparse_matvec_axpby dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .vec_index   (vec_index),
        .major_index (major_index),
        .minor_index (minor_index),
        .value       (value),
        .done        (done),
        .out_index   (out_index),
        .out_value   (out_value),
        .saturated   (saturated),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog on the whole run.
    initial
    begin
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("Timed out after %0d cycles.", cycles_run);
        $display("FAIL sparse_matvec_axpby");
        $finish;
    end

    // Update the stores for one taken beat and queue the result a read returns.
    function automatic void axpby_update(input beat_t b);
        logic [smva_pkg::IDX_W-1:0] dst;
        logic [smva_pkg::IDX_W-1:0] src;
        longint              lhs;
        longint              rhs;
        longint              sum;
        logic signed [127:0] acc_w;
        logic signed [127:0] alpha_w;
        logic signed [127:0] beta_w;
        logic signed [127:0] y_w;
        logic signed [127:0] scaled;
        result_t             r;
        case (b.kind)
            smva_pkg::REQ_LOAD:
            begin
                loads_sent++;
                x_mem[b.vec] = b.val;
                if (!x_loaded[b.vec])
                begin
                    x_loaded[b.vec] = 1'b1;
                    loaded_idx.push_back(b.vec);
                end
            end
            smva_pkg::REQ_ACCUM:
            begin
                nonzeros_sent++;
                dst = mdl_scatter ? b.minor : b.major;
                src = mdl_scatter ? b.major : b.minor;
                lhs = b.val;
                rhs = x_mem[src];
                sum = acc_mem[dst];
                sum = sum + ((lhs * rhs) >>> smva_pkg::FRAC_W);
                if (sum > ACC_HI)
                begin
                    sum = ACC_HI;
                    acc_clip[dst] = 1'b1;
                end
                else if (sum < ACC_LO)
                begin
                    sum = ACC_LO;
                    acc_clip[dst] = 1'b1;
                end
                acc_mem[dst] = sum[smva_pkg::ACC_W-1:0];
            end
            smva_pkg::REQ_READ:
            begin
                reads_sent++;
                acc_w   = acc_mem[b.vec];
                alpha_w = mdl_alpha;
                beta_w  = mdl_beta;
                y_w     = b.val;
                scaled  = (acc_w * alpha_w + beta_w * y_w) >>> smva_pkg::FRAC_W;
                r.idx   = b.vec;
                r.sat   = acc_clip[b.vec];
                if (scaled > RES_HI)
                begin
                    r.val = Q_MAX;
                    r.sat = 1'b1;
                end
                else if (scaled < RES_LO)
                begin
                    r.val = Q_MIN;
                    r.sat = 1'b1;
                end
                else
                begin
                    r.val = scaled[smva_pkg::VAL_W-1:0];
                end
                acc_mem[b.vec]  = '0;
                acc_clip[b.vec] = 1'b0;
                axpby_due.push_back(r);
            end
            default:
            begin
                // The unused request code is dropped by the block.
            end
        endcase
    endfunction

    // Compare each returned element with the oldest pending one.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && done)
        begin
            if (axpby_due.size() == 0)
            begin
                $error("Result for index %0d arrived with none pending", out_index);
                mismatches++;
            end
            else
            begin
                want = axpby_due.pop_front();
                results_checked++;
                if (saturated === 1'b1)
                    results_clipped++;
                if (out_index !== want.idx)
                begin
                    $error("out_index: expected %0d, got %0d", want.idx, out_index);
                    mismatches++;
                end
                if (out_value !== want.val)
                begin
                    $error("out_value: expected %h, got %h", want.val, out_value);
                    mismatches++;
                end
                if (saturated !== want.sat)
                begin
                    $error("saturated: expected %b, got %b", want.sat, saturated);
                    mismatches++;
                end
            end
        end
    end

    // Present one beat and hold it until the block takes it. Start is left
    // high on return so that a following beat can go out back to back.
    task automatic issue_beat(input beat_t b);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start       <= 1'b1;
        req_type    <= b.kind;
        vec_index   <= b.vec;
        major_index <= b.major;
        minor_index <= b.minor;
        value       <= b.val;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        if (b.kind != REQ_UNUSED)
            beats_sent++;
        axpby_update(b);
    endtask

    // Stop sending, wait for every pending result, then let the last
    // nonzero finish its write-back.
    task automatic settle();
        start <= 1'b0;
        while (axpby_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers; only called with the block idle.
    task automatic set_config(input logic scatter,
                              input logic [smva_pkg::VAL_W-1:0] alpha,
                              input logic [smva_pkg::VAL_W-1:0] beta);
        cfg_we    <= 1'b1;
        cfg_index <= smva_pkg::CFG_SCATTER;
        cfg_wdata <= {{(smva_pkg::VAL_W-1){1'b0}}, scatter};
        @(posedge clk);
        mdl_scatter = scatter;
        cfg_index <= smva_pkg::CFG_ALPHA;
        cfg_wdata <= alpha;
        @(posedge clk);
        mdl_alpha = alpha;
        cfg_index <= smva_pkg::CFG_BETA;
        cfg_wdata <= beta;
        @(posedge clk);
        mdl_beta = beta;
        cfg_we <= 1'b0;
    endtask

    function automatic beat_t random_beat();
        beat_t b;
        b.kind  = smva_pkg::REQ_LOAD;
        b.vec   = smva_pkg::IDX_W'($urandom_range(0, smva_pkg::MAX_DIM - 1));
        b.major = smva_pkg::IDX_W'($urandom_range(0, smva_pkg::MAX_DIM - 1));
        b.minor = smva_pkg::IDX_W'($urandom_range(0, smva_pkg::MAX_DIM - 1));
        b.val   = $urandom;
        return b;
    endfunction

    // Mostly values within +-8.0, sometimes any 32-bit pattern.
    function automatic logic [smva_pkg::VAL_W-1:0] rand_q();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return smva_pkg::VAL_W'($urandom_range(0, 1 << 20)) - smva_pkg::VAL_W'(1 << 19);
    endfunction

    function automatic logic [smva_pkg::VAL_W-1:0] pick_scale(input int sel);
        case (sel)
            0:       return Q_ONE;
            1:       return Q_MIN;
            2:       return Q_MAX;
            3:       return '0;
            4:       return rand_q();
            default: return $urandom;
        endcase
    endfunction

    task automatic load_x(input int idx, input logic [smva_pkg::VAL_W-1:0] val);
        beat_t b;
        b      = random_beat();
        b.kind = smva_pkg::REQ_LOAD;
        b.vec  = smva_pkg::IDX_W'(idx);
        b.val  = val;
        issue_beat(b);
    endtask

    task automatic add_nonzero(input int major, input int minor,
                               input logic [smva_pkg::VAL_W-1:0] val);
        beat_t b;
        b       = random_beat();
        b.kind  = smva_pkg::REQ_ACCUM;
        b.major = smva_pkg::IDX_W'(major);
        b.minor = smva_pkg::IDX_W'(minor);
        b.val   = val;
        issue_beat(b);
    endtask

    task automatic read_elem(input int idx, input logic [smva_pkg::VAL_W-1:0] y);
        beat_t b;
        b      = random_beat();
        b.kind = smva_pkg::REQ_READ;
        b.vec  = smva_pkg::IDX_W'(idx);
        b.val  = y;
        issue_beat(b);
    endtask

    // Accumulators start at zero and the reset scales give a plain product.
    task automatic test_reset_values();
        read_elem(7, Q_MAX);
        read_elem(smva_pkg::MAX_DIM - 1, Q_MIN);
    endtask

    // A row summed from two nonzeros in gather mode, then read twice.
    task automatic test_gather_row();
        load_x(0, Q_MIN);
        load_x(smva_pkg::MAX_DIM - 1, Q_MAX);
        load_x(5, Q_ONE);
        load_x(6, Q_NEG_ONE);
        add_nonzero(2, 5, 32'h0003_0000);
        add_nonzero(2, 6, 32'h0000_8000);
        read_elem(2, Q_ONE);
        read_elem(2, Q_ONE);
    endtask

    // Drive accumulators past both 48-bit limits; the clip flag stays set
    // even when a later nonzero pulls the sum back.
    task automatic test_acc_clipping();
        repeat (3) add_nonzero(0, 0, Q_MIN);
        repeat (3) add_nonzero(smva_pkg::MAX_DIM - 1, 0, Q_MAX);
        add_nonzero(smva_pkg::MAX_DIM - 1, smva_pkg::MAX_DIM - 1, Q_MAX);
        read_elem(0, '0);
        read_elem(smva_pkg::MAX_DIM - 1, '0);
    endtask

    // The unused request code must give nothing and change nothing.
    task automatic test_unused_request();
        beat_t b;
        b      = random_beat();
        b.kind = REQ_UNUSED;
        issue_beat(b);
        read_elem(0, Q_ONE);
    endtask

    // Scatter mode and the extreme scale settings, with result clipping.
    task automatic test_scatter_and_scales();
        settle();
        set_config(1'b1, Q_MIN, Q_MAX);
        add_nonzero(5, 3, 32'h0002_0000);
        add_nonzero(smva_pkg::MAX_DIM - 1, 4, Q_MAX);
        read_elem(3, Q_MIN);
        read_elem(4, 32'hFFFF_FFFF);
        settle();
        set_config(1'b0, Q_MAX, Q_MIN);
        add_nonzero(9, 6, Q_ONE);
        read_elem(9, Q_MAX);
        read_elem(9, '0);
    endtask

    // One small sparse matrix: load x, stream nonzeros, read the rows back.
    // Now and then a row is left unread so it carries into the next matrix.
    task automatic matrix_pass();
        int n;
        int nnz;
        int src_base;
        int dst_base;
        int k;
        int src;
        int dst;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
        src_base = $urandom_range(0, smva_pkg::MAX_DIM - n);
        dst_base = $urandom_range(0, smva_pkg::MAX_DIM - n);
        for (k = 0; k < n; k++)
            load_x(src_base + k, rand_q());
        nnz = $urandom_range(n, 3 * n);
        repeat (nnz)
        begin
            src = src_base + $urandom_range(0, n - 1);
            dst = dst_base + $urandom_range(0, n - 1);
            if (mdl_scatter)
                add_nonzero(src, dst, rand_q());
            else
                add_nonzero(dst, src, rand_q());
        end
        for (k = 0; k < n; k++)
            if ($urandom_range(0, 7) != 0)
                read_elem(dst_base + k, rand_q());
    endtask

    // A short burst of loose beats: stray loads, nonzeros, reads and the
    // unused code, in any order.
    task automatic noise_burst();
        int    pick;
        int    src;
        beat_t b;
        repeat ($urandom_range(1, 5))
        begin
            pick = $urandom_range(0, 9);
            b    = random_beat();
            if (pick < 3)
            begin
                b.kind = smva_pkg::REQ_LOAD;
            end
            else if (pick < 6)
            begin
                b.kind = smva_pkg::REQ_ACCUM;
                src    = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
                if (mdl_scatter)
                    b.major = smva_pkg::IDX_W'(src);
                else
                    b.minor = smva_pkg::IDX_W'(src);
            end
            else if (pick < 9)
            begin
                b.kind = smva_pkg::REQ_READ;
            end
            else
            begin
                b.kind = REQ_UNUSED;
            end
            issue_beat(b);
        end
    endtask

    // Random traffic over several register settings and idle profiles.
    task automatic test_random_matrices();
        int phase;
        int target;
        int idle_profile [4];
        idle_profile = '{0, 65, 0, 28};
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            set_config(phase[0], pick_scale(phase % 6), pick_scale((phase + 3) % 6));
            idle_pct = idle_profile[phase % 4];
            target   = beats_sent + RANDOM_BEATS / NUM_PHASES;
            while (beats_sent < target)
            begin
                if ($urandom_range(0, 4) == 0)
                    noise_burst();
                else
                    matrix_pass();
            end
        end
        idle_pct = 0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = smva_pkg::REQ_LOAD;
        vec_index   = '0;
        major_index = '0;
        minor_index = '0;
        value       = '0;
        cfg_we      = 1'b0;
        cfg_index   = smva_pkg::CFG_SCATTER;
        cfg_wdata   = '0;
        mdl_scatter = 1'b0;
        mdl_alpha   = smva_pkg::ALPHA_RESET;
        mdl_beta    = '0;
        idle_pct    = 0;
        beats_sent      = 0;
        loads_sent      = 0;
        nonzeros_sent   = 0;
        reads_sent      = 0;
        results_checked = 0;
        results_clipped = 0;
        mismatches      = 0;
        for (int i = 0; i < smva_pkg::MAX_DIM; i++)
        begin
            x_mem[i]    = '0;
            x_loaded[i] = 1'b0;
            acc_mem[i]  = '0;
            acc_clip[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_gather_row();
        test_acc_clipping();
        test_unused_request();
        test_scatter_and_scales();
        test_random_matrices();
        settle();

        if (axpby_due.size() != 0)
        begin
            $error("%0d results never arrived", axpby_due.size());
            mismatches++;
        end
        $display("Sent %0d beats: %0d x loads, %0d nonzeros, %0d reads, over %0d settings.",
                 beats_sent, loads_sent, nonzeros_sent, reads_sent, NUM_PHASES + 3);
        $display("Checked %0d result elements, %0d of them clipped; %0d mismatches.",
                 results_checked, results_clipped, mismatches);
        if (mismatches == 0)
            $display("PASS sparse_matvec_axpby");
        else
            $display("FAIL sparse_matvec_axpby");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/smva_pkg.sv
sv/smva_ctrl.sv
sv/smva_dp.sv
sv/sparse_matvec_axpby.sv
sv/smva_checker.sv
tb/sv/tb_sparse_matvec_axpby.sv
